### rtl/acia_serial_port_defines.svh
// Assertion helpers for the checker file.
`ifndef ACIA_SERIAL_PORT_DEFINES_SVH
`define ACIA_SERIAL_PORT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define ACIA_SP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define ACIA_SP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/acia_sp_pkg.sv
`timescale 1ns / 1ps
package acia_sp_pkg;

  localparam int POLL_INTERVAL_DEF = 64;

  // item kinds
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // register addresses
  localparam logic [1:0] REG_DATA    = 2'd0;
  localparam logic [1:0] REG_STATUS  = 2'd1;
  localparam logic [1:0] REG_COMMAND = 2'd2;
  localparam logic [1:0] REG_CONTROL = 2'd3;

  // status bit positions
  localparam int ST_PARITY  = 0;
  localparam int ST_FRAMING = 1;
  localparam int ST_OVERRUN = 2;
  localparam int ST_RXFULL  = 3;
  localparam int ST_TXEMPTY = 4;
  localparam int ST_DCD     = 5;
  localparam int ST_DSR     = 6;
  localparam int ST_IRQ     = 7;

  // command bit positions
  localparam int CM_DTR  = 0;
  localparam int CM_IRD  = 1;
  localparam int CM_TIC0 = 2;
  localparam int CM_TIC1 = 3;
  localparam int CM_ECHO = 4;

  localparam logic [1:0] TIC_TX_IRQ      = 2'b01;
  localparam logic [7:0] CMD_KEEP_MASK   = 8'b1110_0000;
  localparam logic [7:0] STATUS_RESET    = 8'h10;
  localparam logic [7:0] DATA_READ_CLR   = 8'h8F;  // irq, rx full, three errors
  localparam logic [7:0] STATUS_RD_MASK  = 8'h9F;  // modem bits read as zero

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       rx_available;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_taken;
    logic       echo_valid;
  } result_t;

endpackage

### rtl/acia_sp_core.sv
`timescale 1ns / 1ps
module acia_sp_core #(
  parameter int POLL_INTERVAL = acia_sp_pkg::POLL_INTERVAL_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  acia_sp_pkg::item_t  item,
  output acia_sp_pkg::result_t res
);

  localparam int CNT_W = $clog2(POLL_INTERVAL + 1);

  logic [7:0]       thr_r, thr_nxt;
  logic [7:0]       rhr_r, rhr_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       ctl_r, ctl_nxt;
  logic [7:0]       st_r, st_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = cnt_r + CNT_W'(1);

  always_comb begin
    thr_nxt  = thr_r;
    rhr_nxt  = rhr_r;
    cmd_nxt  = cmd_r;
    ctl_nxt  = ctl_r;
    st_nxt   = st_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    res      = '0;
    case (item.mode)
      acia_sp_pkg::MODE_READ: begin
        case (item.reg_select)
          acia_sp_pkg::REG_DATA: begin
            res.read_data = rhr_r;
            st_nxt        = st_r & ~acia_sp_pkg::DATA_READ_CLR;
          end
          acia_sp_pkg::REG_STATUS: begin
            res.read_data                = st_r & acia_sp_pkg::STATUS_RD_MASK;
            st_nxt[acia_sp_pkg::ST_IRQ]  = 1'b0;
          end
          acia_sp_pkg::REG_COMMAND: res.read_data = cmd_r;
          default:                  res.read_data = ctl_r;
        endcase
      end
      acia_sp_pkg::MODE_WRITE: begin
        case (item.reg_select)
          acia_sp_pkg::REG_DATA: begin
            thr_nxt                         = item.write_data;
            st_nxt[acia_sp_pkg::ST_TXEMPTY] = 1'b0;
            pend_nxt                        = 1'b1;
          end
          acia_sp_pkg::REG_STATUS: begin
            // programmed reset
            cmd_nxt                         = cmd_r & acia_sp_pkg::CMD_KEEP_MASK;
            st_nxt[acia_sp_pkg::ST_OVERRUN] = 1'b0;
          end
          acia_sp_pkg::REG_COMMAND: cmd_nxt = item.write_data;
          default:                  ctl_nxt = item.write_data;
        endcase
      end
      acia_sp_pkg::MODE_TICK: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= CNT_W'(POLL_INTERVAL)) begin
          cnt_nxt = '0;
          if (cmd_r[acia_sp_pkg::CM_DTR] && !st_r[acia_sp_pkg::ST_RXFULL] &&
              item.rx_available) begin
            rhr_nxt                        = item.rx_byte;
            st_nxt[acia_sp_pkg::ST_RXFULL] = 1'b1;
            res.rx_taken                   = 1'b1;
            res.echo_valid                 = cmd_r[acia_sp_pkg::CM_ECHO];
            if (!cmd_r[acia_sp_pkg::CM_IRD]) begin
              st_nxt[acia_sp_pkg::ST_IRQ] = 1'b1;
            end
          end
        end
        if (pend_r && cmd_r[acia_sp_pkg::CM_DTR]) begin
          res.tx_valid                    = 1'b1;
          res.tx_byte                     = thr_r;
          st_nxt[acia_sp_pkg::ST_TXEMPTY] = 1'b1;
          pend_nxt                        = 1'b0;
          if (cmd_r[acia_sp_pkg::CM_TIC1:acia_sp_pkg::CM_TIC0] == acia_sp_pkg::TIC_TX_IRQ) begin
            st_nxt[acia_sp_pkg::ST_IRQ] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.irq = cmd_nxt[acia_sp_pkg::CM_DTR] & st_nxt[acia_sp_pkg::ST_IRQ];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      rhr_r  <= '0;
      cmd_r  <= '0;
      ctl_r  <= '0;
      st_r   <= acia_sp_pkg::STATUS_RESET;
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else if (fire) begin
      thr_r  <= thr_nxt;
      rhr_r  <= rhr_nxt;
      cmd_r  <= cmd_nxt;
      ctl_r  <= ctl_nxt;
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### rtl/acia_serial_port.sv
`timescale 1ns / 1ps
// Register model of a serial adapter: each item is a bus read, a bus write or a clock
// tick, and each gives exactly one result item. An item is taken into an input register,
// processed against the register state and lands in an output register, so
// the block accepts one item per cycle, and out_tvalid for a result rises when that
// output register is loaded with it.
// Throughput drops only while the output register is stalled by out_tready.
// A tick polls the receive link once every POLL_INTERVAL ticks.
module acia_serial_port #(
  parameter int POLL_INTERVAL = acia_sp_pkg::POLL_INTERVAL_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] write_data, [8] rx_available, [16:9] rx_byte, [23:17] zero
  input  logic [acia_sp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode, [3:2] reg_select
  input  logic [acia_sp_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] read_data, [8] irq, [9] tx_valid, [17:10] tx_byte, [18] rx_taken,
  // [19] echo_valid, [23:20] zero
  output logic [acia_sp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  acia_sp_pkg::item_t   in_item;
  acia_sp_pkg::item_t   item_r;
  acia_sp_pkg::result_t res;
  acia_sp_pkg::result_t res_r;
  logic                 item_vld_r;
  logic                 out_vld_r;
  logic                 out_free;
  logic                 fire;

  assign in_item.mode         = in_tuser[1:0];
  assign in_item.reg_select   = in_tuser[3:2];
  assign in_item.write_data   = in_tdata[7:0];
  assign in_item.rx_available = in_tdata[8];
  assign in_item.rx_byte      = in_tdata[16:9];

  assign out_free  = !out_vld_r || out_tready;
  assign fire      = item_vld_r && out_free;
  assign in_tready = !item_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  acia_sp_core #(
    .POLL_INTERVAL(POLL_INTERVAL)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, res_r.echo_valid, res_r.rx_taken, res_r.tx_byte,
                       res_r.tx_valid, res_r.irq, res_r.read_data};

endmodule

### rtl/acia_sp_checker.sv
`timescale 1ns / 1ps
`include "acia_serial_port_defines.svh"
module acia_sp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [acia_sp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [acia_sp_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [acia_sp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  `ACIA_SP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result item dropped while stalled")
  `ACIA_SP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "result item changed while stalled")
  `ACIA_SP_ASSERT_NOW(a_echo_needs_take, clk, rst_n, out_tvalid && out_tdata[19], out_tdata[18], "echo without a received byte")
  `ACIA_SP_ASSERT_NOW(a_tx_byte_idle, clk, rst_n, out_tvalid && !out_tdata[9], out_tdata[17:10] == 8'h00 && out_tdata[23:20] == 4'h0, "tx byte or padding set without a send")

endmodule

bind acia_serial_port acia_sp_checker u_acia_sp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
